// File: hw/rtl/efr_pkg.sv
// Package with the shared types and constants of the escaped frame receiver.
`default_nettype none
package efr_pkg;

  // Size of the frame buffer in bytes; the store position wraps at this count.
  localparam int BUFFER_BYTES = 64;

  // Width of the store position and of the stored byte count.
  localparam int POS_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W = POS_W + 1;

  // Special line bytes.
  localparam logic [7:0] MARK_BYTE  = 8'hAA;
  localparam logic [7:0] START_BYTE = 8'hBB;

  // One result transaction as held in the output stages.
  typedef struct packed {
    logic       byte_kept;
    logic [5:0] kept_position;
    logic [7:0] kept_value;
    logic       frame_start;
    logic       frame_end;
    logic       check_good;
    logic [7:0] frame_length;
    logic [7:0] frame_command;
    logic       overflow;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/escaped_frame_receiver_core.sv
// Top level of the escaped frame receiver: byte deframer with a skid output stage.
//
// Usage:
//   The input channel (in_valid, in_stall, rx_byte) takes one received serial
//   byte per transaction. The output channel (out_valid, out_stall and the
//   result fields) returns exactly one result transaction per input byte, in
//   order. Each result says whether the byte was stored in the frame, where,
//   and whether it started or ended a frame, with the checksum verdict and the
//   held length and command bytes.
//   A byte accepted at a clock edge has its result registered into the output
//   stage at that edge, or into the skid stage while the output is held.
//   Throughput is one byte per cycle while in_stall is low; the whole state
//   update is a single registered step on the escape flag, position, length, command and XOR.
//   When the receiver stalls, a second result stage takes one more byte, so
//   one byte is still accepted after the stall begins; in_stall rises only
//   while both result stages are full, and falls once the output drains.
//   Reset (rst, synchronous, active high) empties both result stages and
//   clears the escape flag, position, held length, held command and running
//   XOR to zero.
`default_nettype none
module escaped_frame_receiver_core
  import efr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] rx_byte,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       byte_kept,
  output      logic [5:0] kept_position,
  output      logic [7:0] kept_value,
  output      logic       frame_start,
  output      logic       frame_end,
  output      logic       check_good,
  output      logic [7:0] frame_length,
  output      logic [7:0] frame_command,
  output      logic       overflow
);

  // Deframer state.
  logic             escape_pending, escape_pending_next;
  logic [POS_W-1:0] position, position_next;
  logic [7:0]       length_held, length_held_next;
  logic [7:0]       command_held, command_held_next;
  logic [7:0]       running_xor, running_xor_next;

  // Output stage and skid stage.
  logic    out_full, skid_full;
  result_t out_res, skid_res;
  result_t res_next;

  logic in_take, out_take;
  logic [CNT_W-1:0] count;

  assign in_stall = skid_full;
  assign in_take  = in_valid && !skid_full;
  assign out_take = out_full && !out_stall;

  // Next state and result for the byte at the input.
  always_comb begin
    escape_pending_next = escape_pending;
    position_next       = position;
    length_held_next    = length_held;
    command_held_next   = command_held;
    running_xor_next    = running_xor;
    count               = '0;
    res_next            = '0;

    if (escape_pending) begin
      // Byte after a mark: a start byte opens a frame, anything else is dropped.
      escape_pending_next = 1'b0;
      if (rx_byte == START_BYTE) begin
        position_next        = '0;
        res_next.frame_start = 1'b1;
      end
    end else begin
      if (rx_byte == MARK_BYTE) begin
        escape_pending_next = 1'b1;
      end
      res_next.byte_kept     = 1'b1;
      res_next.kept_position = 6'(position);
      res_next.kept_value    = rx_byte;
      if (position == '0) begin
        length_held_next = rx_byte;
        running_xor_next = rx_byte;
      end else begin
        if (position == POS_W'(1)) begin
          command_held_next = rx_byte;
        end
        running_xor_next = running_xor ^ rx_byte;
      end
      count = CNT_W'(position) + CNT_W'(1);
      // The frame ends once length plus one bytes are stored.
      if (9'(count) > {1'b0, length_held_next}) begin
        res_next.frame_end   = 1'b1;
        res_next.check_good  = (running_xor_next == 8'h00);
        count                = '0;
        escape_pending_next  = 1'b0;
      end
      // Wrap at the buffer size.
      if (count >= CNT_W'(BUFFER_BYTES)) begin
        res_next.overflow   = 1'b1;
        count               = '0;
        escape_pending_next = 1'b0;
      end
      position_next = count[POS_W-1:0];
    end
    res_next.frame_length  = length_held_next;
    res_next.frame_command = command_held_next;
  end

  // State registers, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      position       <= '0;
      length_held    <= '0;
      command_held   <= '0;
      running_xor    <= '0;
    end else if (in_take) begin
      escape_pending <= escape_pending_next;
      position       <= position_next;
      length_held    <= length_held_next;
      command_held   <= command_held_next;
      running_xor    <= running_xor_next;
    end
  end

  // Result stages: the skid stage catches a result while the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (skid_full) begin
        if (out_take) begin
          out_res   <= skid_res;
          skid_full <= 1'b0;
        end
      end else if (in_take) begin
        if (out_full && !out_take) begin
          skid_res  <= res_next;
          skid_full <= 1'b1;
        end else begin
          out_res  <= res_next;
          out_full <= 1'b1;
        end
      end else if (out_take) begin
        out_full <= 1'b0;
      end
    end
  end

  // Output ports.
  assign out_valid     = out_full;
  assign byte_kept     = out_res.byte_kept;
  assign kept_position = out_res.kept_position;
  assign kept_value    = out_res.kept_value;
  assign frame_start   = out_res.frame_start;
  assign frame_end     = out_res.frame_end;
  assign check_good    = out_res.check_good;
  assign frame_length  = out_res.frame_length;
  assign frame_command = out_res.frame_command;
  assign overflow      = out_res.overflow;

endmodule
`default_nettype wire

// File: dv/escaped_frame_receiver_core_test.sv
// Self-checking testbench of the escaped frame receiver core with a built-in deframer predictor.
`default_nettype none
module escaped_frame_receiver_core_test;
  import efr_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       byte_kept;
  logic [5:0] kept_position;
  logic [7:0] kept_value;
  logic       frame_start;
  logic       frame_end;
  logic       check_good;
  logic [7:0] frame_length;
  logic [7:0] frame_command;
  logic       overflow;

  // Predicted deframer state.
  logic        esc_pending = 1'b0;
  int unsigned store_pos = 0;
  logic [7:0]  len_held = 8'h00;
  logic [7:0]  cmd_held = 8'h00;
  logic [7:0]  frame_xor = 8'h00;

  // Verdicts predicted for accepted bytes, oldest first.
  result_t     byte_verdicts[$];

  int unsigned sent_count = 0;
  int unsigned mismatch_count = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int unsigned hold_cycles = 0;

  escaped_frame_receiver_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_kept     (byte_kept),
    .kept_position (kept_position),
    .kept_value    (kept_value),
    .frame_start   (frame_start),
    .frame_end     (frame_end),
    .check_good    (check_good),
    .frame_length  (frame_length),
    .frame_command (frame_command),
    .overflow      (overflow)
  );

  always #6 clk = ~clk;

  // Advance the deframer state by one received byte and return its verdict.
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t     v;
    int unsigned next_count;
    v = '0;
    if (esc_pending) begin
      // The byte after a mark is never stored; only a start byte has an effect.
      esc_pending = 1'b0;
      if (b == START_BYTE) begin
        store_pos = 0;
        v.frame_start = 1'b1;
      end
    end else begin
      if (b == MARK_BYTE) begin
        esc_pending = 1'b1;
      end
      v.byte_kept = 1'b1;
      v.kept_position = store_pos[5:0];
      v.kept_value = b;
      if (store_pos == 0) begin
        len_held = b;
        frame_xor = b;
      end else begin
        if (store_pos == 1) begin
          cmd_held = b;
        end
        frame_xor = frame_xor ^ b;
      end
      next_count = store_pos + 1;
      // A completed frame wins over a buffer wrap.
      if (next_count > len_held) begin
        v.frame_end = 1'b1;
        v.check_good = (frame_xor == 8'h00);
        next_count = 0;
        esc_pending = 1'b0;
      end
      if (next_count >= BUFFER_BYTES) begin
        v.overflow = 1'b1;
        next_count = 0;
        esc_pending = 1'b0;
      end
      store_pos = next_count;
    end
    v.frame_length = len_held;
    v.frame_command = cmd_held;
    return v;
  endfunction

  // Offer one byte, with an optional idle burst first, and wait for its acceptance.
  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(negedge clk); while (in_stall);
    byte_verdicts.push_back(deframe_byte(b));
    sent_count++;
    @(posedge clk);
  endtask

  // Send a byte and, after a mark, mostly the stuffing byte.
  task automatic send_stuffed(input logic [7:0] b);
    send_byte(b);
    if (b == MARK_BYTE) begin
      if ($urandom_range(0, 99) < 85) begin
        send_byte(8'h00);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Random byte biased toward the special line bytes.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 4) begin
      return MARK_BYTE;
    end else if (r == 4) begin
      return START_BYTE;
    end else if (r == 5) begin
      return 8'h00;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Stop offering and wait until every predicted verdict has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (byte_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic report_field(input string what, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %s: expected %h, got %h", what, exp_v, act_v);
      end
    end
  endtask

  // Compare each result transaction with the oldest predicted verdict.
  initial begin
    result_t v;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (byte_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result transaction with no byte outstanding");
          end
        end else begin
          v = byte_verdicts.pop_front();
          report_field("byte_kept", 8'(v.byte_kept), 8'(byte_kept));
          report_field("kept_position", 8'(v.kept_position), 8'(kept_position));
          report_field("kept_value", v.kept_value, kept_value);
          report_field("frame_start", 8'(v.frame_start), 8'(frame_start));
          report_field("frame_end", 8'(v.frame_end), 8'(frame_end));
          report_field("check_good", 8'(v.check_good), 8'(check_good));
          report_field("frame_length", v.frame_length, frame_length);
          report_field("frame_command", v.frame_command, frame_command);
          report_field("overflow", 8'(v.overflow), 8'(overflow));
        end
      end
    end
  end

  // Receiver side: random stall bursts, or one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hand-picked bytes for headers, stuffing, dropped escapes and frame edges.
  task automatic test_directed();
    logic [7:0] seq[$];
    // Zero length frame, then a header.
    seq = {8'h00, MARK_BYTE, START_BYTE};
    // Good frame with a stuffed mark inside.
    seq = {seq, 8'h03, 8'h10, MARK_BYTE, 8'h00, 8'hB9};
    // Mark followed by a non-stuffing byte, which is dropped; bad checksum.
    seq = {seq, MARK_BYTE, START_BYTE, 8'h02, MARK_BYTE, 8'h55, 8'hFF};
    // Frame whose last byte is a mark, so the following start byte is data.
    seq = {seq, MARK_BYTE, START_BYTE, 8'h01, MARK_BYTE, START_BYTE};
    // A header in the middle of a long frame restarts it.
    seq = {seq, MARK_BYTE, START_BYTE, 8'h05, 8'h11, MARK_BYTE, START_BYTE};
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
    drain();
  endtask

  // Mostly well-formed frames with random content, plus noise and cut frames.
  task automatic test_random_frames(input int unsigned n_items);
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned r;
    int unsigned stop_at;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(pick_byte());
      end else begin
        send_byte(MARK_BYTE);
        send_byte(START_BYTE);
        r = $urandom_range(0, 99);
        if (r < 80) begin
          len = 8'($urandom_range(0, 12));
        end else if (r < 96) begin
          len = 8'($urandom_range(13, 63));
        end else begin
          len = 8'($urandom_range(64, 255));
        end
        send_stuffed(len);
        sum = len;
        for (int i = 1; i <= len; i++) begin
          if (i == len && $urandom_range(0, 9) != 0) begin
            b = sum;
          end else begin
            b = pick_byte();
          end
          sum = sum ^ b;
          send_stuffed(b);
          if ($urandom_range(0, 99) == 0) begin
            break;
          end
        end
      end
    end
    drain();
  endtask

  // Hold the receiver off while bytes keep coming so the input stalls.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    hold_cycles = 60;
    repeat (80) send_byte(pick_byte());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_frames(1400);
    test_backpressure();
    // Final stretch at full rate on both sides.
    test_random_frames(500);
    if (mismatch_count == 0 && byte_verdicts.size() == 0) begin
      $display("[escaped_frame_receiver_core] OK");
    end else begin
      $display("[escaped_frame_receiver_core] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(12 * 500000);
    $display("[escaped_frame_receiver_core] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
